// File: sv/mxst_pkg.sv
// Package for the maximum XOR subarray trie unit.
// Holds the sequencer state type used by the trie walker; no dependencies.
package mxst_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CREATE,
    ST_LEAF,
    ST_Q_ISSUE,
    ST_Q_WALK,
    ST_I_ISSUE,
    ST_I_WALK,
    ST_DONE
  } state_e;

endpackage

// File: sv/mxst_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module mxst_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/mxst_walker.sv
// Trie sequencer: prefix XOR, query walk, insert walk and node allocation.
// Drives the node memory ports; uses mxst_pkg for the state type.
module mxst_walker #(
  parameter int unsigned KEY_BITS   = 22,
  parameter int unsigned NODE_COUNT = 32768
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [KEY_BITS-1:0]               word_i,
  input  logic                              start_new_i,
  output logic                              res_valid_o,
  input  logic                              res_take_i,
  output logic [KEY_BITS-1:0]               res_best_o,
  output logic                              res_full_o,
  output logic                              mem_we_o,
  output logic [$clog2(NODE_COUNT)-1:0]     mem_waddr_o,
  output logic [2*$clog2(NODE_COUNT)-1:0]   mem_wdata_o,
  output logic                              mem_re_o,
  output logic [$clog2(NODE_COUNT)-1:0]     mem_raddr_o,
  input  logic [2*$clog2(NODE_COUNT)-1:0]   mem_rdata_i
);

  localparam int unsigned NodeW = $clog2(NODE_COUNT);
  localparam int unsigned FreeW = $clog2(NODE_COUNT + 1);
  localparam int unsigned LvlW  = $clog2(KEY_BITS);
  localparam logic [LvlW-1:0] LvlTop = LvlW'(KEY_BITS - 1);

  mxst_pkg::state_e state_q, state_d;

  logic [KEY_BITS-1:0] prefix_q, prefix_d;
  logic [KEY_BITS-1:0] best_q, best_d;
  logic [KEY_BITS-1:0] acc_q, acc_d;
  logic [FreeW-1:0]    free_q, free_d;
  logic                started_q, started_d;
  logic                clearing_q, clearing_d;
  logic                full_q, full_d;
  logic [LvlW-1:0]     lvl_q, lvl_d;
  logic [NodeW-1:0]    node_q, node_d;
  logic [2*NodeW-1:0]  ndata_q, ndata_d;

  logic               accept;
  logic               fresh;
  logic               key_bit;
  logic [NodeW-1:0]   link0, link1, same_link, opp_link, q_next, new_link;
  logic               lvl_last;
  logic [KEY_BITS-1:0] acc_bit, q_acc;
  logic               q_done;
  logic [FreeW:0]     need_sum;
  logic               no_room;
  logic [2*NodeW-1:0] create_data;

  assign accept    = in_valid_i && (state_q == mxst_pkg::ST_IDLE);
  assign fresh     = start_new_i || !started_q;
  assign key_bit   = clearing_q ? 1'b0 : prefix_q[lvl_q];
  assign link0     = mem_rdata_i[NodeW-1:0];
  assign link1     = mem_rdata_i[2*NodeW-1:NodeW];
  assign same_link = key_bit ? link1 : link0;
  assign opp_link  = key_bit ? link0 : link1;
  assign lvl_last  = (lvl_q == '0);
  assign acc_bit   = KEY_BITS'(1) << lvl_q;
  assign q_acc     = (opp_link != '0) ? (acc_q | acc_bit) : acc_q;
  assign q_next    = (opp_link != '0) ? opp_link : same_link;
  assign q_done    = lvl_last || ((opp_link == '0) && (same_link == '0));
  assign need_sum  = (FreeW+1)'(free_q) + (FreeW+1)'(lvl_q) + (FreeW+1)'(1);
  assign no_room   = need_sum > (FreeW+1)'(NODE_COUNT);
  assign new_link  = free_q[NodeW-1:0];
  assign create_data = key_bit ? {new_link, ndata_q[NodeW-1:0]}
                               : {ndata_q[2*NodeW-1:NodeW], new_link};

  always_comb begin
    state_d = state_q;
    case (state_q)
      mxst_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = fresh ? mxst_pkg::ST_CREATE : mxst_pkg::ST_Q_ISSUE;
        end
      end
      mxst_pkg::ST_CREATE: begin
        if (lvl_last) begin
          state_d = mxst_pkg::ST_LEAF;
        end
      end
      mxst_pkg::ST_LEAF: begin
        state_d = clearing_q ? mxst_pkg::ST_Q_ISSUE : mxst_pkg::ST_DONE;
      end
      mxst_pkg::ST_Q_ISSUE: state_d = mxst_pkg::ST_Q_WALK;
      mxst_pkg::ST_Q_WALK: begin
        if (q_done) begin
          state_d = mxst_pkg::ST_I_ISSUE;
        end
      end
      mxst_pkg::ST_I_ISSUE: state_d = mxst_pkg::ST_I_WALK;
      mxst_pkg::ST_I_WALK: begin
        if (same_link == '0) begin
          state_d = no_room ? mxst_pkg::ST_DONE : mxst_pkg::ST_CREATE;
        end else if (lvl_last) begin
          state_d = mxst_pkg::ST_DONE;
        end
      end
      mxst_pkg::ST_DONE: begin
        if (res_take_i) begin
          state_d = mxst_pkg::ST_IDLE;
        end
      end
      default: state_d = mxst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = node_q;
    mem_wdata_o = create_data;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    case (state_q)
      mxst_pkg::ST_CREATE: mem_we_o = 1'b1;
      mxst_pkg::ST_LEAF: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = '0;
      end
      mxst_pkg::ST_Q_ISSUE, mxst_pkg::ST_I_ISSUE: mem_re_o = 1'b1;
      mxst_pkg::ST_Q_WALK: begin
        mem_re_o    = !q_done;
        mem_raddr_o = q_next;
      end
      mxst_pkg::ST_I_WALK: begin
        mem_re_o    = (same_link != '0) && !lvl_last;
        mem_raddr_o = same_link;
      end
      default: ;
    endcase
  end

  always_comb begin
    prefix_d   = prefix_q;
    best_d     = best_q;
    acc_d      = acc_q;
    free_d     = free_q;
    started_d  = started_q;
    clearing_d = clearing_q;
    full_d     = full_q;
    lvl_d      = lvl_q;
    node_d     = node_q;
    ndata_d    = ndata_q;
    case (state_q)
      mxst_pkg::ST_IDLE: begin
        if (accept) begin
          if (fresh) begin
            prefix_d   = word_i;
            best_d     = '0;
            free_d     = FreeW'(1);
            started_d  = 1'b1;
            clearing_d = 1'b1;
            node_d     = '0;
            ndata_d    = '0;
            lvl_d      = LvlTop;
          end else begin
            prefix_d = prefix_q ^ word_i;
          end
        end
      end
      mxst_pkg::ST_CREATE: begin
        node_d  = new_link;
        ndata_d = '0;
        free_d  = free_q + FreeW'(1);
        if (!lvl_last) begin
          lvl_d = lvl_q - LvlW'(1);
        end
      end
      mxst_pkg::ST_LEAF: begin
        clearing_d = 1'b0;
        full_d     = 1'b0;
      end
      mxst_pkg::ST_Q_ISSUE: begin
        lvl_d = LvlTop;
        acc_d = '0;
      end
      mxst_pkg::ST_Q_WALK: begin
        acc_d = q_acc;
        if (q_done) begin
          best_d = (q_acc > best_q) ? q_acc : best_q;
        end else begin
          lvl_d = lvl_q - LvlW'(1);
        end
      end
      mxst_pkg::ST_I_ISSUE: begin
        lvl_d  = LvlTop;
        node_d = '0;
      end
      mxst_pkg::ST_I_WALK: begin
        if (same_link == '0) begin
          if (no_room) begin
            full_d = 1'b1;
          end else begin
            ndata_d = mem_rdata_i;
          end
        end else begin
          node_d = same_link;
          if (lvl_last) begin
            full_d = 1'b0;
          end else begin
            lvl_d = lvl_q - LvlW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mxst_pkg::ST_IDLE;
      prefix_q   <= '0;
      best_q     <= '0;
      free_q     <= FreeW'(1);
      started_q  <= 1'b0;
      clearing_q <= 1'b0;
      full_q     <= 1'b0;
      lvl_q      <= '0;
    end else begin
      state_q    <= state_d;
      prefix_q   <= prefix_d;
      best_q     <= best_d;
      free_q     <= free_d;
      started_q  <= started_d;
      clearing_q <= clearing_d;
      full_q     <= full_d;
      lvl_q      <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    node_q  <= node_d;
    ndata_q <= ndata_d;
  end

  assign in_ready_o  = (state_q == mxst_pkg::ST_IDLE);
  assign res_valid_o = (state_q == mxst_pkg::ST_DONE);
  assign res_best_o  = best_q;
  assign res_full_o  = full_q;

endmodule

// File: sv/max_xor_subarray_trie_unit.sv
// Maximum XOR subarray unit: one item at a time, one node memory access per cycle.
// Each item takes a read issue and a walk of node reads for the query and for the insert,
// one write per new node plus a leaf write, and a load of the output register; a start
// item adds KEY_BITS + 1 writes. A new item is accepted only after the last result has
// been taken into the output register.
// Reset clears control, prefix, best value and allocator; node memory is not cleared.
module max_xor_subarray_trie_unit #(
  parameter int unsigned KEY_BITS   = 22,
  parameter int unsigned NODE_COUNT = 32768
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KEY_BITS-1:0] word_i,
  input  logic                start_new_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [KEY_BITS-1:0] best_xor_o,
  output logic                pool_full_o
);

  localparam int unsigned NodeW = $clog2(NODE_COUNT);

  logic                res_valid, res_take, res_full;
  logic [KEY_BITS-1:0] res_best;
  logic                mem_we, mem_re;
  logic [NodeW-1:0]    mem_waddr, mem_raddr;
  logic [2*NodeW-1:0]  mem_wdata, mem_rdata;

  logic                out_valid_q, out_valid_d;
  logic [KEY_BITS-1:0] best_xor_q;
  logic                pool_full_q;

  mxst_walker #(
    .KEY_BITS   (KEY_BITS),
    .NODE_COUNT (NODE_COUNT)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .word_i      (word_i),
    .start_new_i (start_new_i),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_best_o  (res_best),
    .res_full_o  (res_full),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  mxst_ram #(
    .WIDTH (2 * NodeW),
    .DEPTH (NODE_COUNT)
  ) u_nodes (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_take    = res_valid && (!out_valid_q || out_ready_i);
  assign out_valid_d = res_take || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      best_xor_q  <= res_best;
      pool_full_q <= res_full;
    end
  end

  assign out_valid_o = out_valid_q;
  assign best_xor_o  = best_xor_q;
  assign pool_full_o = pool_full_q;

endmodule
